/* rtl/blt_pkg.sv */
package blt_pkg;

  localparam int ByteW = 8;
  localparam int EvW   = 2;
  localparam int TokW  = 4;
  localparam int ErrW  = 2;

  localparam logic [EvW-1:0] EV_TEXT = 2'd0;
  localparam logic [EvW-1:0] EV_DONE = 2'd1;
  localparam logic [EvW-1:0] EV_ERR  = 2'd2;

  localparam logic [TokW-1:0] TK_ID     = 4'd0;
  localparam logic [TokW-1:0] TK_NUM    = 4'd1;
  localparam logic [TokW-1:0] TK_CHAR   = 4'd2;
  localparam logic [TokW-1:0] TK_LBRACK = 4'd3;
  localparam logic [TokW-1:0] TK_RBRACK = 4'd4;
  localparam logic [TokW-1:0] TK_LPAREN = 4'd5;
  localparam logic [TokW-1:0] TK_RPAREN = 4'd6;
  localparam logic [TokW-1:0] TK_LBRACE = 4'd7;
  localparam logic [TokW-1:0] TK_RBRACE = 4'd8;
  localparam logic [TokW-1:0] TK_COMMA  = 4'd9;
  localparam logic [TokW-1:0] TK_PIPE   = 4'd10;

  localparam logic [ErrW-1:0] ERR_NONE       = 2'd0;
  localparam logic [ErrW-1:0] ERR_INVALID    = 2'd1;
  localparam logic [ErrW-1:0] ERR_UNEXPECTED = 2'd2;

  localparam logic [ByteW-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [ByteW-1:0] CH_DOT        = 8'h2E;
  localparam logic [ByteW-1:0] CH_QUOTE      = 8'h27;
  localparam logic [ByteW-1:0] CH_PIPE       = 8'h7C;
  localparam logic [ByteW-1:0] CH_LBRACK     = 8'h5B;
  localparam logic [ByteW-1:0] CH_RBRACK     = 8'h5D;
  localparam logic [ByteW-1:0] CH_LPAREN     = 8'h28;
  localparam logic [ByteW-1:0] CH_RPAREN     = 8'h29;
  localparam logic [ByteW-1:0] CH_LBRACE     = 8'h7B;
  localparam logic [ByteW-1:0] CH_RBRACE     = 8'h7D;
  localparam logic [ByteW-1:0] CH_COMMA      = 8'h2C;
  localparam logic [ByteW-1:0] CH_SPACE      = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB        = 8'h09;
  localparam logic [ByteW-1:0] CH_CR         = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF         = 8'h0A;

  // one result word
  typedef struct packed {
    logic [EvW-1:0]   ev;
    logic [TokW-1:0]  kind;
    logic [ByteW-1:0] text;
    logic [ErrW-1:0]  err;
    logic             last;
  } res_t;

  // decoder to output buffer: results of one input word
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

endpackage

/* rtl/blt_decode.sv */
module blt_decode import blt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             end_i,
  output res_pair_t        res_o
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ID    = 3'd1;
  localparam logic [2:0] MODE_INT   = 3'd2;
  localparam logic [2:0] MODE_DOT   = 3'd3;
  localparam logic [2:0] MODE_FRAC  = 3'd4;
  localparam logic [2:0] MODE_QOPEN = 3'd5;
  localparam logic [2:0] MODE_QBODY = 3'd6;
  localparam logic [2:0] MODE_ERR   = 3'd7;

  logic [2:0] mode_q, mode_d;

  logic       is_space, is_letter, is_digit;
  logic [TokW-1:0] punct;
  logic       idle_emit;
  res_t       idle_res;
  logic [2:0] idle_mode;
  res_t       done_id, done_num, bad, txt;
  res_t       r0, r1;
  logic [1:0] cnt;

  function automatic res_t mk(logic [EvW-1:0] ev, logic [TokW-1:0] kind,
                              logic [ByteW-1:0] text, logic [ErrW-1:0] err);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.text = text;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  assign is_space  = (byte_i == CH_SPACE) || (byte_i == CH_TAB) ||
                     (byte_i == CH_CR) || (byte_i == CH_LF);
  assign is_letter = ((byte_i >= 8'h61) && (byte_i <= 8'h7A)) ||
                     ((byte_i >= 8'h41) && (byte_i <= 8'h5A));
  assign is_digit  = (byte_i >= 8'h30) && (byte_i <= 8'h39);

  always_comb begin
    case (byte_i)
      CH_LBRACK: punct = TK_LBRACK;
      CH_RBRACK: punct = TK_RBRACK;
      CH_LPAREN: punct = TK_LPAREN;
      CH_RPAREN: punct = TK_RPAREN;
      CH_LBRACE: punct = TK_LBRACE;
      CH_RBRACE: punct = TK_RBRACE;
      CH_COMMA:  punct = TK_COMMA;
      CH_PIPE:   punct = TK_PIPE;
      default:   punct = TK_ID;
    endcase
  end

  assign done_id  = mk(EV_DONE, TK_ID, '0, ERR_NONE);
  assign done_num = mk(EV_DONE, TK_NUM, '0, ERR_NONE);
  assign bad      = mk(EV_ERR, TK_ID, '0, ERR_UNEXPECTED);

  // byte handled from idle, also after a token ends on it
  always_comb begin
    idle_emit = 1'b1;
    idle_res  = mk(EV_ERR, TK_ID, '0, ERR_INVALID);
    idle_mode = MODE_ERR;
    if (is_space) begin
      idle_emit = 1'b0;
      idle_mode = MODE_IDLE;
    end else if (is_letter) begin
      idle_res  = mk(EV_TEXT, TK_ID, byte_i, ERR_NONE);
      idle_mode = MODE_ID;
    end else if (is_digit) begin
      idle_res  = mk(EV_TEXT, TK_NUM, byte_i, ERR_NONE);
      idle_mode = MODE_INT;
    end else if (byte_i == CH_QUOTE) begin
      idle_emit = 1'b0;
      idle_mode = MODE_QOPEN;
    end else if (punct != TK_ID) begin
      idle_res  = mk(EV_DONE, punct, '0, ERR_NONE);
      idle_mode = MODE_IDLE;
    end
  end

  always_comb begin
    cnt    = 2'd0;
    r0     = idle_res;
    r1     = idle_res;
    mode_d = mode_q;
    txt    = mk(EV_TEXT, TK_NUM, byte_i, ERR_NONE);
    if (end_i) begin
      mode_d = MODE_IDLE;
      case (mode_q)
        MODE_ID: begin
          cnt = 2'd1;
          r0  = done_id;
        end
        MODE_INT, MODE_FRAC: begin
          cnt = 2'd1;
          r0  = done_num;
        end
        MODE_DOT, MODE_QOPEN, MODE_QBODY: begin
          cnt = 2'd1;
          r0  = bad;
        end
        default: cnt = 2'd0;
      endcase
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          cnt    = {1'b0, idle_emit};
          mode_d = idle_mode;
        end
        MODE_ID: begin
          if (is_letter || is_digit || (byte_i == CH_UNDERSCORE)) begin
            cnt = 2'd1;
            r0  = mk(EV_TEXT, TK_ID, byte_i, ERR_NONE);
          end else begin
            cnt    = idle_emit ? 2'd2 : 2'd1;
            r0     = done_id;
            mode_d = idle_mode;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            cnt = 2'd1;
            r0  = txt;
          end else if (byte_i == CH_DOT) begin
            cnt    = 2'd1;
            r0     = txt;
            mode_d = MODE_DOT;
          end else begin
            cnt    = idle_emit ? 2'd2 : 2'd1;
            r0     = done_num;
            mode_d = idle_mode;
          end
        end
        MODE_DOT: begin
          cnt = 2'd1;
          if (is_digit) begin
            r0     = txt;
            mode_d = MODE_FRAC;
          end else begin
            r0     = bad;
            mode_d = MODE_ERR;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            cnt = 2'd1;
            r0  = txt;
          end else begin
            cnt    = idle_emit ? 2'd2 : 2'd1;
            r0     = done_num;
            mode_d = idle_mode;
          end
        end
        MODE_QOPEN: begin
          cnt = 2'd1;
          if (byte_i == CH_QUOTE) begin
            r0     = bad;
            mode_d = MODE_ERR;
          end else begin
            r0     = mk(EV_TEXT, TK_CHAR, byte_i, ERR_NONE);
            mode_d = MODE_QBODY;
          end
        end
        MODE_QBODY: begin
          cnt = 2'd1;
          if (byte_i == CH_QUOTE) begin
            r0     = mk(EV_DONE, TK_CHAR, '0, ERR_NONE);
            mode_d = MODE_IDLE;
          end else begin
            r0     = bad;
            mode_d = MODE_ERR;
          end
        end
        default: mode_d = MODE_ERR;
      endcase
    end
  end

  // mark the last result of this word
  always_comb begin
    res_o.cnt     = cnt;
    res_o.r0      = r0;
    res_o.r1      = r1;
    res_o.r0.last = (cnt == 2'd1);
    res_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

/* rtl/blt_outbuf.sv */
module blt_outbuf import blt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  res_pair_t res_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_t      out_res_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       s0_q, s0_d, s1_q, s1_d;
  logic       pop, push;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  // take a new word once the buffer drains this cycle
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = s0_q;

  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (push) begin
      cnt_d = res_i.cnt;
      s0_d  = res_i.r0;
      s1_d  = res_i.r1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      s0_d  = s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

/* rtl/bracket_language_tokenizer_top.sv */
// Channel  Dir  tdata                             tuser                        tlast
// s_axis   in   [7:0] byte_in                     -                            end_of_input
// m_axis   out  [7:0] text_byte, [9:8] error_code [1:0] event_kind,            last_of_run
//                                                 [5:2] token_kind
//
// A word is decoded against the scan mode as it is taken and its results land in a
// two-entry output buffer the same cycle. Words that give zero or one result flow at
// one per cycle while m_axis is ready; a word that ends a token and starts another (two
// results) holds s_axis while the buffer drains. Reset clears the scan mode to idle
// and empties the buffer. A stalled m_axis holds the head result steady.
module bracket_language_tokenizer_top import blt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] text_byte, [9:8] error_code, rest zero
  output logic [5:0]  m_axis_tuser,   // [1:0] event_kind, [5:2] token_kind
  output logic        m_axis_tlast    // last_of_run
);

  res_pair_t res;
  res_t      head;
  logic      accept;

  // the scan mode advances only on a taken word
  assign accept = s_axis_tvalid && s_axis_tready;

  blt_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .res_o    (res)
  );

  blt_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (head)
  );

  assign m_axis_tdata = {6'd0, head.err, head.text};
  assign m_axis_tuser = {head.kind, head.ev};
  assign m_axis_tlast = head.last;

endmodule

/* tb/sv/bracket_language_tokenizer_top_tb.sv */
`timescale 1ns / 100ps

module bracket_language_tokenizer_top_tb;
  import blt_pkg::*;

  localparam int ItemTarget  = 350;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int PrintCap    = 40;

  // scanner modes of the local tokenizer model
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_ID, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_QOPEN, SCAN_QBODY, SCAN_ERR
  } scan_e;

  // one source word as queued for the driver
  typedef struct {
    logic [ByteW-1:0] ch;
    logic             eoi;
    bit               hold;   // wait for every due event before presenting
  } src_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] byte_in
  logic        s_axis_tlast = 1'b0; // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] text_byte, [9:8] error_code
  logic [5:0]  m_axis_tuser;        // [1:0] event_kind, [5:2] token_kind
  logic        m_axis_tlast;        // last_of_run

  scan_e     scan_mode_q = SCAN_IDLE;
  res_t      events_due[$];
  src_word_t source_words[$];
  src_word_t word_on_bus;
  res_t      want_ev;
  bit        hold_next = 1'b0;
  int        words_taken = 0;
  int        total_words = 1;
  int        mismatches = 0;
  int        cycles = 0;

  bracket_language_tokenizer_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  function automatic bit is_letter(logic [ByteW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit is_digit(logic [ByteW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void emit(logic [EvW-1:0] ev, logic [TokW-1:0] kind,
                               logic [ByteW-1:0] text, logic [ErrW-1:0] err);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.text = text;
    r.err  = err;
    r.last = 1'b0;
    events_due.push_back(r);
  endfunction

  // malformed number or char literal
  function automatic void reject_char();
    emit(EV_ERR, '0, '0, ERR_UNEXPECTED);
    scan_mode_q = SCAN_ERR;
  endfunction

  // a byte seen with the scanner idle, also the lookahead byte that ends a token
  function automatic void start_token(logic [ByteW-1:0] ch);
    scan_mode_q = SCAN_IDLE;
    case (ch)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
      end
      CH_QUOTE:  scan_mode_q = SCAN_QOPEN;
      CH_LBRACK: emit(EV_DONE, TK_LBRACK, '0, ERR_NONE);
      CH_RBRACK: emit(EV_DONE, TK_RBRACK, '0, ERR_NONE);
      CH_LPAREN: emit(EV_DONE, TK_LPAREN, '0, ERR_NONE);
      CH_RPAREN: emit(EV_DONE, TK_RPAREN, '0, ERR_NONE);
      CH_LBRACE: emit(EV_DONE, TK_LBRACE, '0, ERR_NONE);
      CH_RBRACE: emit(EV_DONE, TK_RBRACE, '0, ERR_NONE);
      CH_COMMA:  emit(EV_DONE, TK_COMMA, '0, ERR_NONE);
      CH_PIPE:   emit(EV_DONE, TK_PIPE, '0, ERR_NONE);
      default: begin
        if (is_letter(ch)) begin
          emit(EV_TEXT, TK_ID, ch, ERR_NONE);
          scan_mode_q = SCAN_ID;
        end else if (is_digit(ch)) begin
          emit(EV_TEXT, TK_NUM, ch, ERR_NONE);
          scan_mode_q = SCAN_INT;
        end else begin
          emit(EV_ERR, '0, '0, ERR_INVALID);
          scan_mode_q = SCAN_ERR;
        end
      end
    endcase
  endfunction

  // queue the events one accepted word causes and advance the scan mode
  function automatic void predict_tokens(src_word_t w);
    int   n_before;
    res_t tail;
    n_before = events_due.size();
    if (w.eoi) begin
      case (scan_mode_q)
        SCAN_ID:                          emit(EV_DONE, TK_ID, '0, ERR_NONE);
        SCAN_INT, SCAN_FRAC:              emit(EV_DONE, TK_NUM, '0, ERR_NONE);
        SCAN_DOT, SCAN_QOPEN, SCAN_QBODY: emit(EV_ERR, '0, '0, ERR_UNEXPECTED);
        default: begin
        end
      endcase
      scan_mode_q = SCAN_IDLE;
    end else begin
      case (scan_mode_q)
        SCAN_IDLE: start_token(w.ch);
        SCAN_ID: begin
          if (is_letter(w.ch) || is_digit(w.ch) || w.ch == CH_UNDERSCORE) begin
            emit(EV_TEXT, TK_ID, w.ch, ERR_NONE);
          end else begin
            emit(EV_DONE, TK_ID, '0, ERR_NONE);
            start_token(w.ch);
          end
        end
        SCAN_INT: begin
          if (is_digit(w.ch)) begin
            emit(EV_TEXT, TK_NUM, w.ch, ERR_NONE);
          end else if (w.ch == CH_DOT) begin
            emit(EV_TEXT, TK_NUM, w.ch, ERR_NONE);
            scan_mode_q = SCAN_DOT;
          end else begin
            emit(EV_DONE, TK_NUM, '0, ERR_NONE);
            start_token(w.ch);
          end
        end
        SCAN_DOT: begin
          if (is_digit(w.ch)) begin
            emit(EV_TEXT, TK_NUM, w.ch, ERR_NONE);
            scan_mode_q = SCAN_FRAC;
          end else begin
            reject_char();
          end
        end
        SCAN_FRAC: begin
          if (is_digit(w.ch)) begin
            emit(EV_TEXT, TK_NUM, w.ch, ERR_NONE);
          end else begin
            emit(EV_DONE, TK_NUM, '0, ERR_NONE);
            start_token(w.ch);
          end
        end
        SCAN_QOPEN: begin
          if (w.ch == CH_QUOTE) begin
            reject_char();
          end else begin
            emit(EV_TEXT, TK_CHAR, w.ch, ERR_NONE);
            scan_mode_q = SCAN_QBODY;
          end
        end
        SCAN_QBODY: begin
          if (w.ch == CH_QUOTE) begin
            emit(EV_DONE, TK_CHAR, '0, ERR_NONE);
            scan_mode_q = SCAN_IDLE;
          end else begin
            reject_char();
          end
        end
        default: begin
          // error mode: drop until end of input
        end
      endcase
    end
    if (events_due.size() > n_before) begin
      tail = events_due.pop_back();
      tail.last = 1'b1;
      events_due.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_word(logic [ByteW-1:0] ch, logic eoi);
    src_word_t w;
    w.ch   = ch;
    w.eoi  = eoi;
    w.hold = hold_next;
    hold_next = 1'b0;
    source_words.push_back(w);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_word(s[i], 1'b0);
  endfunction

  function automatic logic [ByteW-1:0] any_letter();
    return 8'($urandom_range(25, 0)) + ($urandom_range(1, 0) ? 8'h61 : 8'h41);
  endfunction

  function automatic logic [ByteW-1:0] any_digit();
    return 8'h30 + 8'($urandom_range(9, 0));
  endfunction

  function automatic logic [ByteW-1:0] non_quote();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == CH_QUOTE);
    return b;
  endfunction

  // phase 0: sender idles rarely, receiver often; phase 1 the reverse; phase 2 none
  function automatic int idle_phase();
    return (words_taken * 3) / total_words;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < PrintCap)
      $display("%0t tokenizer event %s: got %0h want %0h", $time, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: holds a word until taken, idles per phase, honors hold-off words
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tokens(word_on_bus);
        words_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (source_words.size() != 0 &&
            $urandom_range(99, 0) >= (idle_phase() == 0 ? 8 : idle_phase() == 1 ? 54 : 0) &&
            !(source_words[0].hold && events_due.size() != 0)) begin
          word_on_bus = source_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word_on_bus.ch;
          s_axis_tlast  <= word_on_bus.eoi;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest due event
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (events_due.size() == 0) begin
          report_mismatch("unexpected", {m_axis_tuser, m_axis_tdata[9:0]}, '0);
        end else begin
          want_ev = events_due.pop_front();
          if (m_axis_tuser[1:0] != want_ev.ev)
            report_mismatch("event_kind", 16'(m_axis_tuser[1:0]), 16'(want_ev.ev));
          if (m_axis_tuser[5:2] != want_ev.kind)
            report_mismatch("token_kind", 16'(m_axis_tuser[5:2]), 16'(want_ev.kind));
          if (m_axis_tdata[7:0] != want_ev.text)
            report_mismatch("text_byte", 16'(m_axis_tdata[7:0]), 16'(want_ev.text));
          if (m_axis_tdata[9:8] != want_ev.err)
            report_mismatch("error_code", 16'(m_axis_tdata[9:8]), 16'(want_ev.err));
          if (m_axis_tdata[15:10] != '0)
            report_mismatch("tdata pad", 16'(m_axis_tdata[15:10]), '0);
          if (m_axis_tlast != want_ev.last)
            report_mismatch("last_of_run", 16'(m_axis_tlast), 16'(want_ev.last));
        end
      end
      m_axis_tready <= $urandom_range(99, 0) >=
                       (idle_phase() == 0 ? 54 : idle_phase() == 1 ? 8 : 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("bracket_language_tokenizer_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [ByteW-1:0] punct_chars[8];
    logic [ByteW-1:0] space_chars[4];
    logic [ByteW-1:0] b;
    int               n_seg;
    int               len;
    int               n_random;

    punct_chars = '{CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
                    CH_LBRACE, CH_RBRACE, CH_COMMA, CH_PIPE};
    space_chars = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    // directed: every token kind but the right parenthesis, lookahead ends, all whitespace, identifier
    // flushed by end of input
    queue_text("a_9(0.5]'x'[{},| \t\r\nZ");
    queue_word(8'h00, 1'b1);
    // invalid byte, then a dropped byte in error mode
    queue_word(8'hFF, 1'b0);
    queue_word(8'h61, 1'b0);
    queue_word(8'hA5, 1'b1);
    // number cut off at its dot
    queue_text("1.");
    queue_word(8'h5A, 1'b1);

    // random sentences: well-formed tokens, sometimes ending broken, then end of input
    n_random = ItemTarget;
    hold_next = 1'b1;
    while (source_words.size() < n_random) begin
      if ($urandom_range(9, 0) == 0) hold_next = 1'b1;
      n_seg = $urandom_range(8, 1);
      for (int k = 0; k < n_seg; k++) begin
        case ($urandom_range(9, 0))
          0, 1, 2: begin
            queue_word(any_letter(), 1'b0);
            len = $urandom_range(5, 0);
            for (int i = 0; i < len; i++) begin
              case ($urandom_range(3, 0))
                0, 1: queue_word(any_letter(), 1'b0);
                2: queue_word(any_digit(), 1'b0);
                default: queue_word(CH_UNDERSCORE, 1'b0);
              endcase
            end
          end
          3, 4: begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++) queue_word(any_digit(), 1'b0);
            if ($urandom_range(1, 0)) begin
              queue_word(CH_DOT, 1'b0);
              len = $urandom_range(3, 1);
              for (int i = 0; i < len; i++) queue_word(any_digit(), 1'b0);
            end
          end
          5: begin
            queue_word(CH_QUOTE, 1'b0);
            queue_word(non_quote(), 1'b0);
            queue_word(CH_QUOTE, 1'b0);
          end
          6, 7: queue_word(punct_chars[$urandom_range(7, 0)], 1'b0);
          default: begin
            // tokens often abut with no separator at all
            if ($urandom_range(1, 0)) begin
              len = $urandom_range(2, 1);
              for (int i = 0; i < len; i++)
                queue_word(space_chars[$urandom_range(3, 0)], 1'b0);
            end
          end
        endcase
      end
      case ($urandom_range(9, 0))
        0: queue_word(8'($urandom_range(255, 0)), 1'b0);
        1: begin
          // malformed decimal
          queue_word(any_digit(), 1'b0);
          queue_word(CH_DOT, 1'b0);
          do b = 8'($urandom_range(255, 0)); while (is_digit(b));
          queue_word(b, 1'b0);
        end
        2: begin
          // empty char literal
          queue_word(CH_QUOTE, 1'b0);
          queue_word(CH_QUOTE, 1'b0);
        end
        3: begin
          // char literal not closed by a quote
          queue_word(CH_QUOTE, 1'b0);
          queue_word(non_quote(), 1'b0);
          queue_word(non_quote(), 1'b0);
        end
        4: begin
          // lone underscore or dot from idle
          queue_word(CH_SPACE, 1'b0);
          queue_word($urandom_range(1, 0) ? CH_UNDERSCORE : CH_DOT, 1'b0);
        end
        5: begin
          // cut off by end of input inside a literal or after a dot
          case ($urandom_range(2, 0))
            0: queue_word(CH_QUOTE, 1'b0);
            1: begin
              queue_word(CH_QUOTE, 1'b0);
              queue_word(non_quote(), 1'b0);
            end
            default: begin
              queue_word(any_digit(), 1'b0);
              queue_word(CH_DOT, 1'b0);
            end
          endcase
        end
        default: begin
        end
      endcase
      if ($urandom_range(3, 0) == 0) begin
        // bytes after a possible error, dropped until end of input
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++) queue_word(8'($urandom_range(255, 0)), 1'b0);
      end
      queue_word(8'($urandom_range(255, 0)), 1'b1);
    end
    total_words = source_words.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (source_words.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("bracket_language_tokenizer_top: match");
    end else begin
      $display("bracket_language_tokenizer_top: mismatch");
    end
    $finish;
  end

endmodule
